// ----- hw/rtl/tscr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscr_pkg: shared types and helpers for timestamp clock recovery
// payload structs, sequencer codes, saturating fixed-point helpers
// ----------------------------------------------------------------------------
package tscr_pkg;

    localparam int SLOPE_FRAC_BITS = 40;
    localparam int DECAY_Q16       = 62259;

    typedef logic signed [63:0] t_s64;

    localparam t_s64 S64_MAX = {1'b0, {63{1'b1}}};
    localparam t_s64 S64_MIN = {1'b1, {63{1'b0}}};

    // register indexes of the configuration port
    localparam logic [1:0] CFG_NUM_POINTS      = 2'd0;
    localparam logic [1:0] CFG_MAX_JITTER      = 2'd1;
    localparam logic [1:0] CFG_MIN_POINTS      = 2'd2;
    localparam logic [1:0] CFG_ERROR_THRESHOLD = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [63:0] input_time;
        logic [63:0] output_time;
    } t_in;

    typedef struct packed {
        logic [63:0] mapped_time;
        logic        resynced;
        logic        fit_ready;
    } t_out;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD, OP_ORG,
        OP_PA_GO, OP_PA_PUT, OP_PB_GO, OP_PB_PUT, OP_DIFF,
        OP_DR_GO, OP_DR_PUT, OP_CHK, OP_PREV,
        OP_E_GO, OP_E_PUT, OP_CLAMP, OP_XY,
        OP_FX_GO, OP_FX_PUT, OP_FY_GO, OP_FY_PUT,
        OP_SQ_GO, OP_SQ_PUT, OP_FXX_GO, OP_FXX_PUT,
        OP_XYM_GO, OP_XYM_PUT, OP_FXY_GO, OP_FXY_PUT,
        OP_VA_GO, OP_VA_PUT, OP_CV_GO, OP_CV_PUT,
        OP_SL_GO, OP_SL_PUT, OP_OF_GO, OP_OF_PUT,
        OP_CNT, OP_O_GO, OP_O_PUT
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE, S_ORG,
        S_PA_GO, S_PA_WT, S_PB_GO, S_PB_WT, S_DIFF,
        S_DR_GO, S_DR_WT, S_CHK, S_PREV,
        S_E_GO, S_E_WT, S_CLAMP, S_XY,
        S_FX_GO, S_FX_WT, S_FY_GO, S_FY_WT,
        S_SQ_GO, S_SQ_WT, S_FXX_GO, S_FXX_WT,
        S_XYM_GO, S_XYM_WT, S_FXY_GO, S_FXY_WT,
        S_VA_GO, S_VA_WT, S_CV_GO, S_CV_WT,
        S_SL_GO, S_SL_WT, S_OF_GO, S_OF_WT,
        S_CNT, S_O_GO, S_O_WT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic prev_nz;
        logic fit_go;
        logic var_pos;
        logic mul_busy;
        logic div_busy;
        logic out_free;
    } t_status;

    function automatic t_s64 sat_add(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic t_s64 sat_sub(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic t_s64 sat_shl8(input t_s64 v);
        if (v[63:55] != {9{v[63]}}) return v[63] ? S64_MIN : S64_MAX;
        return {v[55:0], 8'b0};
    endfunction

    function automatic logic [63:0] mag(input t_s64 v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic t_s64 from_mag(input logic [63:0] m, input logic neg);
        if (!neg) return m[63] ? S64_MAX : t_s64'(m);
        return m[63] ? S64_MIN : t_s64'(-m);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/timestamp_clock_recovery_fit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_clock_recovery_fit: maps source clock timestamps onto a target
// clock through a running least-squares line fit
//
// One request at a time. A sample request (mode 0) updates the averages,
// runs the drift check when a previous sample is held and refits slope and
// offset once the count exceeds min_points; a convert request (mode 1) only
// maps its timestamp. The pace is set by the shared restoring divider, which
// gives one quotient bit per cycle, and by the shared multiplier, which
// builds each 64x64 product from four 32x32 partial products. The result
// waits in an output register, so a new request can be taken while it is
// still held. Configuration is written through a plain write port; the user
// must write it only while the block is idle; the block does not check it.
// Indexes 0..3 are num_points, max_jitter, min_points, error_threshold.
// ----------------------------------------------------------------------------
module timestamp_clock_recovery_fit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // configuration write port
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [31:0]    i_cfg_data,
    // request channel
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tscr_pkg::t_in  i_in_req,
    // result channel
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output tscr_pkg::t_out      o_out_rsp
);
    import tscr_pkg::*;

    // operation code from the sequencer, flags back from the datapath
    t_cmd    w_cmd;
    t_status w_st;

    // sequencer: walks each request through its steps
    tscr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // datapath: fit state, config registers, multiplier and divider
    tscr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .o_out_rsp   (o_out_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_st        (w_st)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/tscr_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscr_mul: shared signed multiplier with shift
// 64x64 magnitude product from four 32x32 partial products, then a
// truncating right shift and saturation to signed 64 bits
// ----------------------------------------------------------------------------
module tscr_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire tscr_pkg::t_s64    i_a,
    input  wire tscr_pkg::t_s64    i_b,
    input  wire logic [6:0]        i_shift,
    output logic                   o_busy,
    output tscr_pkg::t_s64         o_res
);
    import tscr_pkg::*;

    logic [63:0]  r_ma, r_mb;
    logic         r_neg;
    logic [6:0]   r_shift;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_pos;
    logic         r_pp_vld;
    logic [127:0] r_acc;
    t_s64         r_res;

    logic [31:0]  w_ah, w_bh;
    logic [127:0] w_sh;

    assign w_ah = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_bh = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_sh = r_acc >> r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pp_vld <= 1'b0;
            r_cnt    <= '0;
        end else if (i_start) begin
            r_ma     <= mag(i_a);
            r_mb     <= mag(i_b);
            r_neg    <= i_a[63] ^ i_b[63];
            r_shift  <= i_shift;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_pp_vld <= 1'b0;
            r_busy   <= 1'b1;
        end else if (r_busy) begin
            if (r_pp_vld) begin
                r_acc <= r_acc + ({64'b0, r_pp} << {r_pp_pos, 5'b0});
            end
            if (r_cnt <= 3'd3) begin
                r_pp     <= w_ah * w_bh;
                r_pp_pos <= 2'({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]});
                r_pp_vld <= 1'b1;
            end else begin
                r_pp_vld <= 1'b0;
            end
            if (r_cnt == 3'd5) begin
                // overflow past 64 bits saturates
                r_res  <= from_mag((|w_sh[127:64]) ? '1 : w_sh[63:0], r_neg);
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 3'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ----- hw/rtl/tscr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscr_div: shared restoring divider
// (|num| << sh) / den, one quotient bit per cycle, truncated and saturated;
// sh of zero runs a plain 64-bit division
// ----------------------------------------------------------------------------
module tscr_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire tscr_pkg::t_s64    i_num,
    input  wire logic [63:0]       i_den,
    input  wire logic [5:0]        i_sh,
    output logic                   o_busy,
    output tscr_pkg::t_s64         o_res
);
    import tscr_pkg::*;

    logic [127:0] r_d;
    logic [63:0]  r_rem, r_q, r_den;
    logic         r_sat, r_neg, r_busy;
    logic [7:0]   r_cnt;
    t_s64         r_res;

    logic [64:0]  w_t;
    logic         w_ge;

    assign w_t  = {r_rem, r_d[127]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            if (i_sh == 6'd0) begin
                r_d   <= {mag(i_num), 64'b0};
                r_cnt <= 8'd64;
            end else begin
                r_d   <= {64'b0, mag(i_num)} << i_sh;
                r_cnt <= 8'd128;
            end
            r_neg  <= i_num[63];
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            r_sat  <= 1'b0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_cnt != 8'd0) begin
                if (r_q[63]) r_sat <= 1'b1;
                r_rem <= w_ge ? 64'(w_t - {1'b0, r_den}) : w_t[63:0];
                r_q   <= {r_q[62:0], w_ge};
                r_d   <= {r_d[126:0], 1'b0};
                r_cnt <= r_cnt - 8'd1;
            end else begin
                r_res  <= from_mag(r_sat ? '1 : r_q, r_neg);
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ----- hw/rtl/tscr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscr_datapath: fit state, configuration and the shared arithmetic units
// carries out one sequencer operation per cycle
// ----------------------------------------------------------------------------
module tscr_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    input  wire tscr_pkg::t_in     i_in_req,
    output tscr_pkg::t_out         o_out_rsp,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire tscr_pkg::t_cmd    i_cmd,
    output tscr_pkg::t_status      o_st
);
    import tscr_pkg::*;

    localparam logic [6:0] SH_PRED  = 7'(SLOPE_FRAC_BITS - 8);
    localparam logic [6:0] SH_SLOPE = 7'(SLOPE_FRAC_BITS);
    localparam logic [5:0] SH_DIV   = 6'(SLOPE_FRAC_BITS - 12);

    // configuration
    logic [9:0]  r_num_points, r_min_points;
    logic [31:0] r_max_jitter, r_err_thr;

    // model state
    t_s64        r_prev_in, r_prev_out, r_in_org, r_out_org;
    t_s64        r_mx, r_my, r_mxx, r_mxy, r_slope, r_offset, r_drift;
    logic [9:0]  r_count;
    logic        r_fit_valid;

    // request and scratch
    logic        r_mode, r_resync;
    t_s64        r_ti, r_to, r_pa, r_pb, r_diff, r_e, r_oc, r_x, r_y;
    t_s64        r_tmp, r_var, r_cov;
    t_out        r_out;
    logic        r_ovalid;

    // unit hookup
    logic        w_mul_start, w_mul_busy, w_div_start, w_div_busy;
    t_s64        w_mul_a, w_mul_b, w_mul_res, w_div_num, w_div_res;
    logic [6:0]  w_mul_sh;
    logic [63:0] w_div_den;
    logic [5:0]  w_div_sh;

    t_s64        w_dx_ti, w_dx_pb, w_d, w_jit;
    logic [10:0] w_c1;

    function automatic t_s64 pred(input t_s64 prod, input t_s64 dx,
                                  input t_s64 off, input t_s64 org);
        t_s64 v;
        v = sat_add(prod, off);
        return (v >>> 8) + dx + org;
    endfunction

    assign w_dx_ti = r_ti - r_in_org;
    assign w_dx_pb = r_prev_in - r_in_org;
    assign w_c1    = {1'b0, r_count} + 11'd1;
    assign w_jit   = t_s64'({32'b0, r_max_jitter});

    always_comb begin
        w_d = r_to - r_e;
        if (w_d > w_jit) w_d = w_jit;
        if (w_d < -w_jit) w_d = -w_jit;
    end

    always_comb begin
        w_mul_start = 1'b1;
        w_mul_a     = r_slope;
        w_mul_b     = w_dx_ti;
        w_mul_sh    = SH_PRED;
        case (i_cmd.op)
            OP_PA_GO, OP_E_GO, OP_O_GO: ;
            OP_PB_GO:  w_mul_b = w_dx_pb;
            OP_DR_GO: begin
                w_mul_a  = r_drift;
                w_mul_b  = t_s64'(DECAY_Q16);
                w_mul_sh = 7'd16;
            end
            OP_SQ_GO: begin
                w_mul_a  = r_x;
                w_mul_b  = r_x;
                w_mul_sh = 7'd24;
            end
            OP_XYM_GO: begin
                w_mul_a  = r_x;
                w_mul_b  = r_y;
                w_mul_sh = 7'd12;
            end
            OP_VA_GO: begin
                w_mul_a  = r_mx;
                w_mul_b  = r_mx;
                w_mul_sh = 7'd40;
            end
            OP_CV_GO: begin
                w_mul_a  = r_mx;
                w_mul_b  = r_my;
                w_mul_sh = 7'd28;
            end
            OP_OF_GO: begin
                w_mul_b  = r_mx;
                w_mul_sh = SH_SLOPE;
            end
            default: w_mul_start = 1'b0;
        endcase
    end

    always_comb begin
        w_div_start = 1'b1;
        w_div_den   = {53'b0, w_c1};
        w_div_sh    = 6'd0;
        w_div_num   = '0;
        case (i_cmd.op)
            OP_FX_GO:  w_div_num = sat_sub(sat_shl8(r_x), r_mx);
            OP_FY_GO:  w_div_num = sat_sub(sat_shl8(r_y), r_my);
            OP_FXX_GO: w_div_num = sat_sub(r_tmp, r_mxx);
            OP_FXY_GO: w_div_num = sat_sub(r_tmp, r_mxy);
            OP_SL_GO: begin
                w_div_num = r_cov;
                w_div_den = r_var;
                w_div_sh  = SH_DIV;
            end
            default: w_div_start = 1'b0;
        endcase
    end

    tscr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_shift (w_mul_sh),
        .o_busy  (w_mul_busy),
        .o_res   (w_mul_res)
    );

    tscr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_sh    (w_div_sh),
        .o_busy  (w_div_busy),
        .o_res   (w_div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= 10'd100;
            r_max_jitter <= 32'd2000;
            r_min_points <= 10'd10;
            r_err_thr    <= 32'd50000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_POINTS:      r_num_points <= i_cfg_data[9:0];
                CFG_MAX_JITTER:      r_max_jitter <= i_cfg_data;
                CFG_MIN_POINTS:      r_min_points <= i_cfg_data[9:0];
                CFG_ERROR_THRESHOLD: r_err_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_in   <= '0;
            r_prev_out  <= '0;
            r_in_org    <= '0;
            r_out_org   <= '0;
            r_mx        <= '0;
            r_my        <= '0;
            r_mxx       <= '0;
            r_mxy       <= '0;
            r_count     <= '0;
            r_slope     <= '0;
            r_offset    <= '0;
            r_drift     <= '0;
            r_fit_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_resync    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready && i_cmd.op != OP_O_PUT) r_ovalid <= 1'b0;
            case (i_cmd.op)
                OP_LOAD: begin
                    r_mode   <= i_in_req.mode;
                    r_ti     <= i_in_req.input_time;
                    r_to     <= i_in_req.output_time;
                    r_resync <= 1'b0;
                end
                OP_ORG: begin
                    if (r_count == 10'd0) begin
                        r_in_org  <= r_ti;
                        r_out_org <= r_to;
                    end
                end
                OP_PA_PUT: r_pa <= pred(w_mul_res, w_dx_ti, r_offset, r_out_org);
                OP_PB_PUT: r_pb <= pred(w_mul_res, w_dx_pb, r_offset, r_out_org);
                OP_DIFF:   r_diff <= sat_shl8((r_to - r_prev_out) - (r_pa - r_pb));
                OP_DR_PUT: r_drift <= sat_add(w_mul_res, r_diff);
                OP_CHK: begin
                    r_prev_in  <= r_ti;
                    r_prev_out <= r_to;
                    // drift past the threshold: drop the fit and restart here
                    if (mag(r_drift) > {24'b0, r_err_thr, 8'b0}) begin
                        r_mx        <= '0;
                        r_my        <= '0;
                        r_mxx       <= '0;
                        r_mxy       <= '0;
                        r_count     <= '0;
                        r_slope     <= '0;
                        r_offset    <= '0;
                        r_drift     <= '0;
                        r_fit_valid <= 1'b0;
                        r_in_org    <= r_ti;
                        r_out_org   <= r_to;
                        r_resync    <= 1'b1;
                    end
                end
                OP_PREV: begin
                    r_prev_in  <= r_ti;
                    r_prev_out <= r_to;
                end
                OP_E_PUT:  r_e <= pred(w_mul_res, w_dx_ti, r_offset, r_out_org);
                OP_CLAMP:  r_oc <= r_e + w_d;
                OP_XY: begin
                    r_x <= w_dx_ti;
                    r_y <= r_oc - r_out_org - w_dx_ti;
                end
                OP_FX_PUT:  r_mx  <= sat_add(r_mx, w_div_res);
                OP_FY_PUT:  r_my  <= sat_add(r_my, w_div_res);
                OP_FXX_PUT: r_mxx <= sat_add(r_mxx, w_div_res);
                OP_FXY_PUT: r_mxy <= sat_add(r_mxy, w_div_res);
                OP_SQ_PUT, OP_XYM_PUT: r_tmp <= w_mul_res;
                OP_VA_PUT:  r_var <= sat_sub(r_mxx, w_mul_res);
                OP_CV_PUT:  r_cov <= sat_sub(r_mxy, w_mul_res);
                OP_SL_PUT:  r_slope <= w_div_res;
                OP_OF_PUT: begin
                    r_offset    <= sat_sub(r_my, w_mul_res);
                    r_fit_valid <= 1'b1;
                end
                OP_CNT: begin
                    if (w_c1 < {1'b0, r_num_points}) r_count <= r_count + 10'd1;
                end
                OP_O_PUT: begin
                    r_out.mapped_time <= pred(w_mul_res, w_dx_ti, r_offset, r_out_org);
                    r_out.resynced    <= r_resync;
                    r_out.fit_ready   <= r_fit_valid;
                    r_ovalid          <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_rsp   = r_out;
    assign o_out_valid = r_ovalid;

    assign o_st.mode     = r_mode;
    assign o_st.prev_nz  = r_prev_out != '0;
    assign o_st.fit_go   = r_count > r_min_points;
    assign o_st.var_pos  = !r_var[63] && (r_var != '0);
    assign o_st.mul_busy = w_mul_busy;
    assign o_st.div_busy = w_div_busy;
    assign o_st.out_free = !r_ovalid || i_out_ready;

endmodule
`default_nettype wire

// ----- hw/rtl/tscr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscr_ctrl: sequencer for one request, which ends by mapping its timestamp;
// a sample request first steps the datapath through drift check, clamp, averaging and refit
// ----------------------------------------------------------------------------
module tscr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire tscr_pkg::t_status i_st,
    output tscr_pkg::t_cmd         o_cmd
);
    import tscr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_ORG;
            S_ORG: begin
                if (i_st.mode)         n_state = S_O_GO;
                else if (i_st.prev_nz) n_state = S_PA_GO;
                else                   n_state = S_PREV;
            end
            S_PA_GO:  n_state = S_PA_WT;
            S_PA_WT:  if (!i_st.mul_busy) n_state = S_PB_GO;
            S_PB_GO:  n_state = S_PB_WT;
            S_PB_WT:  if (!i_st.mul_busy) n_state = S_DIFF;
            S_DIFF:   n_state = S_DR_GO;
            S_DR_GO:  n_state = S_DR_WT;
            S_DR_WT:  if (!i_st.mul_busy) n_state = S_CHK;
            S_CHK:    n_state = S_E_GO;
            S_PREV:   n_state = S_E_GO;
            S_E_GO:   n_state = S_E_WT;
            S_E_WT:   if (!i_st.mul_busy) n_state = S_CLAMP;
            S_CLAMP:  n_state = S_XY;
            S_XY:     n_state = S_FX_GO;
            S_FX_GO:  n_state = S_FX_WT;
            S_FX_WT:  if (!i_st.div_busy) n_state = S_FY_GO;
            S_FY_GO:  n_state = S_FY_WT;
            S_FY_WT:  if (!i_st.div_busy) n_state = S_SQ_GO;
            S_SQ_GO:  n_state = S_SQ_WT;
            S_SQ_WT:  if (!i_st.mul_busy) n_state = S_FXX_GO;
            S_FXX_GO: n_state = S_FXX_WT;
            S_FXX_WT: if (!i_st.div_busy) n_state = S_XYM_GO;
            S_XYM_GO: n_state = S_XYM_WT;
            S_XYM_WT: if (!i_st.mul_busy) n_state = S_FXY_GO;
            S_FXY_GO: n_state = S_FXY_WT;
            S_FXY_WT: begin
                if (!i_st.div_busy) n_state = i_st.fit_go ? S_VA_GO : S_CNT;
            end
            S_VA_GO:  n_state = S_VA_WT;
            S_VA_WT:  if (!i_st.mul_busy) n_state = S_CV_GO;
            S_CV_GO:  n_state = S_CV_WT;
            S_CV_WT: begin
                if (!i_st.mul_busy) n_state = S_SL_GO;
            end
            S_SL_GO: begin
                // zero or negative variance keeps the old slope
                n_state = i_st.var_pos ? S_SL_WT : S_OF_GO;
            end
            S_SL_WT:  if (!i_st.div_busy) n_state = S_OF_GO;
            S_OF_GO:  n_state = S_OF_WT;
            S_OF_WT:  if (!i_st.mul_busy) n_state = S_CNT;
            S_CNT:    n_state = S_O_GO;
            S_O_GO:   n_state = S_O_WT;
            S_O_WT:   if (!i_st.mul_busy && i_st.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_ORG:    if (!i_st.mode) o_cmd.op = OP_ORG;
            S_PA_GO:  o_cmd.op = OP_PA_GO;
            S_PA_WT:  if (!i_st.mul_busy) o_cmd.op = OP_PA_PUT;
            S_PB_GO:  o_cmd.op = OP_PB_GO;
            S_PB_WT:  if (!i_st.mul_busy) o_cmd.op = OP_PB_PUT;
            S_DIFF:   o_cmd.op = OP_DIFF;
            S_DR_GO:  o_cmd.op = OP_DR_GO;
            S_DR_WT:  if (!i_st.mul_busy) o_cmd.op = OP_DR_PUT;
            S_CHK:    o_cmd.op = OP_CHK;
            S_PREV:   o_cmd.op = OP_PREV;
            S_E_GO:   o_cmd.op = OP_E_GO;
            S_E_WT:   if (!i_st.mul_busy) o_cmd.op = OP_E_PUT;
            S_CLAMP:  o_cmd.op = OP_CLAMP;
            S_XY:     o_cmd.op = OP_XY;
            S_FX_GO:  o_cmd.op = OP_FX_GO;
            S_FX_WT:  if (!i_st.div_busy) o_cmd.op = OP_FX_PUT;
            S_FY_GO:  o_cmd.op = OP_FY_GO;
            S_FY_WT:  if (!i_st.div_busy) o_cmd.op = OP_FY_PUT;
            S_SQ_GO:  o_cmd.op = OP_SQ_GO;
            S_SQ_WT:  if (!i_st.mul_busy) o_cmd.op = OP_SQ_PUT;
            S_FXX_GO: o_cmd.op = OP_FXX_GO;
            S_FXX_WT: if (!i_st.div_busy) o_cmd.op = OP_FXX_PUT;
            S_XYM_GO: o_cmd.op = OP_XYM_GO;
            S_XYM_WT: if (!i_st.mul_busy) o_cmd.op = OP_XYM_PUT;
            S_FXY_GO: o_cmd.op = OP_FXY_GO;
            S_FXY_WT: if (!i_st.div_busy) o_cmd.op = OP_FXY_PUT;
            S_VA_GO:  o_cmd.op = OP_VA_GO;
            S_VA_WT:  if (!i_st.mul_busy) o_cmd.op = OP_VA_PUT;
            S_CV_GO:  o_cmd.op = OP_CV_GO;
            S_CV_WT:  if (!i_st.mul_busy) o_cmd.op = OP_CV_PUT;
            S_SL_GO:  if (i_st.var_pos) o_cmd.op = OP_SL_GO;
            S_SL_WT:  if (!i_st.div_busy) o_cmd.op = OP_SL_PUT;
            S_OF_GO:  o_cmd.op = OP_OF_GO;
            S_OF_WT:  if (!i_st.mul_busy) o_cmd.op = OP_OF_PUT;
            S_CNT:    o_cmd.op = OP_CNT;
            S_O_GO:   o_cmd.op = OP_O_GO;
            S_O_WT: begin
                if (!i_st.mul_busy && i_st.out_free) o_cmd.op = OP_O_PUT;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
